### rtl/srr_pkg.sv
package srr_pkg;

	localparam int DEFAULT_WINDOW = 16;

	// Queue between front and back; must be a power of two
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] KIND_DELIVER = 2'd0;
	localparam logic [1:0] KIND_RR      = 2'd1;
	localparam logic [1:0] KIND_SREJ    = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	typedef struct packed {
		logic [31:0] seq;
		logic        eof;
		logic [15:0] tag;
	} pkt_t;

	typedef struct packed {
		logic valid;
		pkt_t pkt;
	} head_t;

endpackage

### rtl/srr_front.sv
module srr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pkt_valid,
	output logic            pkt_ready,
	input  logic [31:0]     seq_num,
	input  logic            is_eof,
	input  logic            checksum_ok,
	input  logic [15:0]     payload_tag,
	output srr_pkg::head_t  head,
	input  logic            pop
);

	localparam int PW = $clog2(srr_pkg::QUEUE_DEPTH);
	localparam logic [PW:0] FULL = (PW+1)'(srr_pkg::QUEUE_DEPTH);

	srr_pkg::pkt_t entry_q [srr_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push;
	logic          do_pop;

	assign pkt_ready = (count_q != FULL);
	// drop packets with a bad checksum at the door
	assign push      = pkt_valid && pkt_ready && checksum_ok;
	assign do_pop    = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.pkt   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{seq: seq_num, eof: is_eof, tag: payload_tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/srr_back.sv
module srr_back #(
	parameter int WINDOW = srr_pkg::DEFAULT_WINDOW
) (
	input  logic           clk,
	input  logic           arst_n,
	input  srr_pkg::head_t head,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_ready,
	output logic [1:0]     kind,
	output logic [31:0]    seq_value,
	output logic [15:0]    out_tag,
	output logic           last
);

	localparam int SW = $clog2(WINDOW);
	localparam int GW = $clog2(WINDOW + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);
	localparam logic [SW:0]   WSUM      = (SW+1)'(WINDOW);
	localparam logic [31:0]   WIN32     = 32'(WINDOW);
	localparam logic [GW-1:0] GMAX      = GW'(WINDOW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_FLUSH_RR,
		ST_SREJ,
		ST_RR_FINAL
	} state_t;

	typedef enum logic [1:0] {
		MODE_INORDER,
		MODE_BUFFER,
		MODE_DONE
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic [31:0]     exp_q, exp_d;
	logic [31:0]     high_q, high_d;
	logic [SW-1:0]   eslot_q, eslot_d;
	logic [GW-1:0]   guard_q, guard_d;
	logic [WINDOW-1:0] valid_q, valid_d;
	logic [15:0]     tag_mem [WINDOW];

	logic        res_valid_q, res_valid_d;
	logic [1:0]  kind_q, kind_d;
	logic [31:0] seq_q, seq_d;
	logic [15:0] tag_q, tag_d;
	logic        last_q, last_d;

	logic          can_load;
	logic [31:0]   exp_inc;
	logic [SW-1:0] eslot_inc;
	logic [31:0]   diff;
	logic          ahead, same, beyond;
	logic [SW:0]   sum;
	logic [SW-1:0] wslot;
	logic          nvalid_inc, nvalid_cur, inc_below, cur_below;
	logic          more_flush, gap;
	logic          tag_we;

	assign can_load = !res_valid_q || res_ready;
	assign exp_inc  = exp_q + 32'd1;
	// slot tracks exp mod WINDOW; the 32-bit wrap restarts it at zero
	assign eslot_inc = (&exp_q) ? '0 : ((eslot_q == LAST_SLOT) ? '0 : eslot_q + SW'(1));

	assign diff   = head.pkt.seq - exp_q;
	assign ahead  = head.pkt.seq > exp_q;
	assign same   = head.pkt.seq == exp_q;
	assign beyond = ahead && (diff >= WIN32);

	// within the window the distance is below WINDOW, so one subtract wraps it
	assign sum   = {1'b0, eslot_q} + {1'b0, diff[SW-1:0]};
	assign wslot = (sum >= WSUM) ? SW'(sum - WSUM) : sum[SW-1:0];

	assign nvalid_inc = valid_q[eslot_inc];
	assign nvalid_cur = valid_q[eslot_q];
	assign inc_below  = exp_inc < high_q;
	assign cur_below  = exp_q < high_q;
	assign more_flush = (guard_q < GMAX) && nvalid_cur;
	assign gap        = cur_below && !nvalid_cur;

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		exp_d       = exp_q;
		high_d      = high_q;
		eslot_d     = eslot_q;
		guard_d     = guard_q;
		valid_d     = valid_q;
		res_valid_d = res_valid_q && !res_ready;
		kind_d      = kind_q;
		seq_d       = seq_q;
		tag_d       = tag_q;
		last_d      = last_q;
		pop         = 1'b0;
		tag_we      = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (head.valid && can_load) begin
					pop = 1'b1;
					if (mode_q != MODE_INORDER && mode_q != MODE_BUFFER) begin
						// finished: ignore everything until reset
					end else if (head.pkt.eof && (exp_q > head.pkt.seq)) begin
						res_valid_d = 1'b1;
						kind_d      = srr_pkg::KIND_DONE;
						seq_d       = head.pkt.seq;
						tag_d       = '0;
						last_d      = 1'b1;
						mode_d      = MODE_DONE;
					end else if (beyond) begin
						// drop
					end else if (mode_q == MODE_INORDER) begin
						if (same) begin
							res_valid_d = 1'b1;
							kind_d      = srr_pkg::KIND_DELIVER;
							seq_d       = head.pkt.seq;
							tag_d       = head.pkt.tag;
							last_d      = 1'b0;
							high_d      = exp_q;
							exp_d       = exp_inc;
							eslot_d     = eslot_inc;
							state_d     = ST_RR_FINAL;
						end else if (ahead) begin
							res_valid_d    = 1'b1;
							kind_d         = srr_pkg::KIND_SREJ;
							seq_d          = exp_q;
							tag_d          = '0;
							last_d         = 1'b1;
							valid_d[wslot] = 1'b1;
							tag_we         = 1'b1;
							high_d         = head.pkt.seq;
							mode_d         = MODE_BUFFER;
						end else begin
							res_valid_d = 1'b1;
							kind_d      = srr_pkg::KIND_RR;
							seq_d       = exp_q;
							tag_d       = '0;
							last_d      = 1'b1;
						end
					end else begin
						if (same) begin
							res_valid_d = 1'b1;
							kind_d      = srr_pkg::KIND_DELIVER;
							seq_d       = head.pkt.seq;
							tag_d       = head.pkt.tag;
							last_d      = !(nvalid_inc || inc_below);
							exp_d       = exp_inc;
							eslot_d     = eslot_inc;
							guard_d     = '0;
							if (nvalid_inc) begin
								state_d = ST_FLUSH;
							end else if (inc_below) begin
								state_d = ST_SREJ;
							end else begin
								mode_d = MODE_INORDER;
							end
						end else if (ahead) begin
							valid_d[wslot] = 1'b1;
							tag_we         = 1'b1;
							if (head.pkt.seq > high_q) begin
								high_d = head.pkt.seq;
							end
						end
					end
				end
			end
			ST_FLUSH: begin
				if (can_load) begin
					res_valid_d      = 1'b1;
					kind_d           = srr_pkg::KIND_DELIVER;
					seq_d            = exp_q;
					tag_d            = tag_mem[eslot_q];
					last_d           = 1'b0;
					valid_d[eslot_q] = 1'b0;
					exp_d            = exp_inc;
					eslot_d          = eslot_inc;
					guard_d          = guard_q + GW'(1);
					state_d          = ST_FLUSH_RR;
				end
			end
			ST_FLUSH_RR: begin
				if (can_load) begin
					res_valid_d = 1'b1;
					kind_d      = srr_pkg::KIND_RR;
					seq_d       = exp_q;
					tag_d       = '0;
					last_d      = !(more_flush || gap);
					if (more_flush) begin
						state_d = ST_FLUSH;
					end else if (gap) begin
						state_d = ST_SREJ;
					end else begin
						mode_d  = MODE_INORDER;
						state_d = ST_IDLE;
					end
				end
			end
			ST_SREJ: begin
				if (can_load) begin
					res_valid_d = 1'b1;
					kind_d      = srr_pkg::KIND_SREJ;
					seq_d       = exp_q;
					tag_d       = '0;
					last_d      = 1'b0;
					state_d     = ST_RR_FINAL;
				end
			end
			ST_RR_FINAL: begin
				if (can_load) begin
					res_valid_d = 1'b1;
					kind_d      = srr_pkg::KIND_RR;
					seq_d       = exp_q;
					tag_d       = '0;
					last_d      = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[wslot] <= head.pkt.tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_INORDER;
			exp_q       <= '0;
			high_q      <= '0;
			eslot_q     <= '0;
			guard_q     <= '0;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
			kind_q      <= srr_pkg::KIND_DELIVER;
			seq_q       <= '0;
			tag_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			exp_q       <= exp_d;
			high_q      <= high_d;
			eslot_q     <= eslot_d;
			guard_q     <= guard_d;
			valid_q     <= valid_d;
			res_valid_q <= res_valid_d;
			kind_q      <= kind_d;
			seq_q       <= seq_d;
			tag_q       <= tag_d;
			last_q      <= last_d;
		end
	end

	assign res_valid = res_valid_q;
	assign kind      = kind_q;
	assign seq_value = seq_q;
	assign out_tag   = tag_q;
	assign last      = last_q;

endmodule

### rtl/selective_repeat_receiver.sv
// Selective-repeat receiver: packets enter a four-entry queue at up to one per cycle while
// it is not full, with bad-checksum packets dropped on entry; the back end takes at most one
// packet from the queue per cycle, only while idle with its single output register free, and
// writes at most one result per cycle into that register, held while res_ready is low: a drop
// gives no result, an in-order deliver is followed by an RR, and each flushed stored packet
// gives a deliver and an RR. Early packets are held in WINDOW slots, whose valid bits reset clears.
module selective_repeat_receiver #(
	parameter int WINDOW = srr_pkg::DEFAULT_WINDOW
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	output logic        pkt_ready,
	input  logic [31:0] seq_num,
	input  logic        is_eof,
	input  logic        checksum_ok,
	input  logic [15:0] payload_tag,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  kind,
	output logic [31:0] seq_value,
	output logic [15:0] out_tag,
	output logic        last
);

	srr_pkg::head_t head;
	logic           pop;

	srr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt_valid   (pkt_valid),
		.pkt_ready   (pkt_ready),
		.seq_num     (seq_num),
		.is_eof      (is_eof),
		.checksum_ok (checksum_ok),
		.payload_tag (payload_tag),
		.head        (head),
		.pop         (pop)
	);

	srr_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.kind      (kind),
		.seq_value (seq_value),
		.out_tag   (out_tag),
		.last      (last)
	);

	// nothing follows the finished notice
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && kind == srr_pkg::KIND_DONE |=> !res_valid)
		else $error("result after transfer finished");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != srr_pkg::KIND_DELIVER |-> out_tag == '0)
		else $error("nonzero tag on a non-deliver result");

	// a full queue always has a packet at its head
	assert property (@(posedge clk) disable iff (!arst_n)
		!pkt_ready |-> head.valid)
		else $error("queue full but head empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == srr_pkg::KIND_DONE |-> last)
		else $error("finished notice not marked last");

endmodule

### tb/selective_repeat_receiver_tb.sv
`timescale 1ns / 100ps

module selective_repeat_receiver_tb;

	localparam int WIN = srr_pkg::DEFAULT_WINDOW;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 90;

	typedef enum logic [1:0] {
		RX_INORDER,
		RX_BUFFER,
		RX_DONE
	} rx_mode_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq;
		logic [15:0] tag;
		logic        last;
	} action_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pkt_valid = 1'b0;
	logic        pkt_ready;
	logic [31:0] seq_num = '0;
	logic        is_eof = 1'b0;
	logic        checksum_ok = 1'b0;
	logic [15:0] payload_tag = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [1:0]  kind;
	logic [31:0] seq_value;
	logic [15:0] out_tag;
	logic        last;

	// receiver state as seen from the packet stream
	rx_mode_t    rx_mode = RX_INORDER;
	logic [31:0] next_seq = '0;
	logic [31:0] top_seq = '0;
	bit          held [WIN];
	logic [15:0] held_tag [WIN];

	action_t     due_actions [$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          steady = 1'b0;
	int          hold_request = 0;
	int          stall_left = 0;

	selective_repeat_receiver #(
		.WINDOW(WIN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_ready(pkt_ready),
		.seq_num(seq_num),
		.is_eof(is_eof),
		.checksum_ok(checksum_ok),
		.payload_tag(payload_tag),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.kind(kind),
		.seq_value(seq_value),
		.out_tag(out_tag),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic action_t make_action(input logic [1:0] k, input logic [31:0] s,
			input logic [15:0] t);
		make_action = {k, s, t, 1'b0};
	endfunction

	// Advance the receiver state for one accepted packet and queue the actions it causes
	function automatic void receive_packet(input logic [31:0] s, input logic e, input logic ok,
			input logic [15:0] t);
		action_t acts [$];
		action_t a;
		int g;
		if (rx_mode == RX_DONE || !ok)
			return;
		if (e && next_seq > s) begin
			acts.push_back(make_action(srr_pkg::KIND_DONE, s, 16'h0000));
			rx_mode = RX_DONE;
		end else if (s > next_seq && (s - next_seq) >= WIN) begin
			// beyond the window: drop
		end else if (rx_mode == RX_INORDER) begin
			if (s == next_seq) begin
				acts.push_back(make_action(srr_pkg::KIND_DELIVER, s, t));
				top_seq = next_seq;
				next_seq++;
				acts.push_back(make_action(srr_pkg::KIND_RR, next_seq, 16'h0000));
			end else if (s > next_seq) begin
				acts.push_back(make_action(srr_pkg::KIND_SREJ, next_seq, 16'h0000));
				held[s % WIN] = 1'b1;
				held_tag[s % WIN] = t;
				top_seq = s;
				rx_mode = RX_BUFFER;
			end else begin
				acts.push_back(make_action(srr_pkg::KIND_RR, next_seq, 16'h0000));
			end
		end else begin
			if (s == next_seq) begin
				acts.push_back(make_action(srr_pkg::KIND_DELIVER, s, t));
				next_seq++;
				for (g = 0; g < WIN && held[next_seq % WIN]; g++) begin
					acts.push_back(make_action(srr_pkg::KIND_DELIVER, next_seq,
						held_tag[next_seq % WIN]));
					held[next_seq % WIN] = 1'b0;
					next_seq++;
					acts.push_back(make_action(srr_pkg::KIND_RR, next_seq, 16'h0000));
				end
				if (next_seq < top_seq && !held[next_seq % WIN]) begin
					acts.push_back(make_action(srr_pkg::KIND_SREJ, next_seq, 16'h0000));
					acts.push_back(make_action(srr_pkg::KIND_RR, next_seq, 16'h0000));
					rx_mode = RX_BUFFER;
				end else begin
					rx_mode = RX_INORDER;
				end
			end else if (s > next_seq) begin
				held[s % WIN] = 1'b1;
				held_tag[s % WIN] = t;
				if (s > top_seq)
					top_seq = s;
			end
		end
		for (int i = 0; i < acts.size(); i++) begin
			a = acts[i];
			a.last = (i == acts.size() - 1);
			due_actions.push_back(a);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_packet(input logic [31:0] s, input logic e, input logic ok,
			input logic [15:0] t);
		int gap;
		pkt_valid <= 1'b1;
		seq_num <= s;
		is_eof <= e;
		checksum_ok <= ok;
		payload_tag <= t;
		@(posedge clk);
		while (!pkt_ready)
			@(posedge clk);
		receive_packet(s, e, ok, t);
		gap = pick_gap();
		if (gap > 0) begin
			pkt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random flags and tag for a packet; an EOF mark is only set where it cannot end the transfer
	task automatic send_mixed(input logic [31:0] s, inout int counted);
		logic ok;
		logic e;
		ok = ($urandom_range(0, 19) != 0);
		e = ($urandom_range(0, 7) == 0) && (s >= next_seq || !ok);
		if (ok && (s <= next_seq || (s - next_seq) < WIN))
			counted++;
		send_packet(s, e, ok, 16'($urandom));
	endtask

	always @(posedge clk) begin
		if (hold_request > 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			res_ready <= 1'b0;
			stall_left--;
		end else if (steady || $urandom_range(0, 99) < 70) begin
			res_ready <= 1'b1;
		end else begin
			res_ready <= 1'b0;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin : check_results
		action_t got;
		action_t want;
		if (arst_n && res_valid && res_ready) begin
			got = {kind, seq_value, out_tag, last};
			if (due_actions.size() == 0) begin
				$display("%0t: unexpected result: kind=%0d seq=%0d tag=%h last=%b",
					$time, got.kind, got.seq, got.tag, got.last);
				mismatches++;
			end else begin
				want = due_actions.pop_front();
				if (got !== want) begin
					$write("%0t: expected kind=%0d seq=%0d tag=%h last=%b, ",
						$time, want.kind, want.seq, want.tag, want.last);
					$display("got kind=%0d seq=%0d tag=%h last=%b",
						got.kind, got.seq, got.tag, got.last);
					mismatches++;
				end
			end
		end
	end

	task automatic test_in_order();
		send_packet(32'd0, 1'b0, 1'b1, 16'h0000);
		send_packet(32'd1, 1'b0, 1'b1, 16'hFFFF);
		// older packet is answered with RR
		send_packet(32'd0, 1'b0, 1'b1, 16'h1234);
		send_packet(32'd2, 1'b0, 1'b0, 16'h5A5A);
		send_packet(32'hFFFF_FFFF, 1'b0, 1'b1, 16'hA5A5);
		send_packet(32'd2 + WIN, 1'b0, 1'b1, 16'h0F0F);
		// EOF at the expected number is plain data
		send_packet(32'd2, 1'b1, 1'b1, 16'hFFFF);
		// bad checksum wins over an ending EOF
		send_packet(32'd1, 1'b1, 1'b0, 16'h0000);
	endtask

	task automatic test_buffering();
		logic [31:0] base;
		base = next_seq;
		send_packet(base + 2, 1'b0, 1'b1, 16'h1111);
		send_packet(base + WIN - 1, 1'b1, 1'b1, 16'h2222);
		send_packet(base + 4, 1'b0, 1'b1, 16'h3333);
		// duplicate overwrites the stored tag
		send_packet(base + 4, 1'b0, 1'b1, 16'h4444);
		send_packet(base - 2, 1'b0, 1'b1, 16'h5555);
		send_packet(base + WIN, 1'b0, 1'b1, 16'h6666);
		send_packet(base, 1'b0, 1'b1, 16'h7777);
		send_packet(base + 1, 1'b0, 1'b1, 16'h8888);
		send_packet(base + 3, 1'b0, 1'b1, 16'h9999);
		send_packet(base + 8, 1'b0, 1'b1, 16'hAAAA);
	endtask

	task automatic test_backpressure();
		steady = 1'b1;
		hold_request = 300;
		for (int i = 0; i < 24; i++)
			send_packet(next_seq + 32'(i % 3), 1'b0, 1'b1, 16'($urandom));
		steady = 1'b0;
	endtask

	task automatic test_random();
		int counted;
		int k;
		int pick;
		int d;
		int tmp;
		int order [WIN];
		logic [31:0] base;
		logic [31:0] s;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				steady = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 2) == 0) begin
				// a window chunk from the expected number, shuffled or reversed
				base = next_seq;
				k = $urandom_range(2, WIN);
				for (int i = 0; i < k; i++)
					order[i] = ($urandom_range(0, 1) == 0) ? i : k - 1 - i;
				for (int i = k - 1; i > 0; i--) begin
					pick = $urandom_range(0, i);
					tmp = order[i];
					order[i] = order[pick];
					order[pick] = tmp;
				end
				if ($urandom_range(0, 1) == 0)
					for (int i = 0; i < k; i++)
						order[i] = k - 1 - i;
				for (int i = 0; i < k; i++)
					send_mixed(base + 32'(order[i]), counted);
			end else begin
				pick = $urandom_range(0, 99);
				d = (next_seq < 20) ? int'(next_seq) : 20;
				if (pick < 40)
					s = next_seq;
				else if (pick < 72)
					s = next_seq + 32'($urandom_range(1, WIN - 1));
				else if (pick < 82 && d > 0)
					s = next_seq - 32'($urandom_range(1, d));
				else if (pick < 90)
					s = next_seq + 32'($urandom_range(WIN, 3 * WIN));
				else
					s = $urandom;
				send_mixed(s, counted);
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_end_of_transfer();
		send_packet(next_seq - 1, 1'b1, 1'b0, 16'h0000);
		send_packet(next_seq - 1, 1'b1, 1'b1, 16'hFFFF);
		// finished: everything after is ignored
		for (int i = 0; i < 4; i++)
			send_packet(next_seq + 32'(i) - 1, 1'($urandom), 1'b1, 16'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_in_order();
		test_buffering();
		test_backpressure();
		test_random();
		test_end_of_transfer();
		pkt_valid <= 1'b0;
		while (due_actions.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && due_actions.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
